// File: sv/neighbor_table_with_aging_assert.svh
// ----------------------------------------------------------------------------
// Neighbor table assertion macros
// Implication checks on one clock with asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_TABLE_WITH_AGING_ASSERT_SVH
`define NEIGHBOR_TABLE_WITH_AGING_ASSERT_SVH

// same-cycle implication
`define NTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("neighbor table assertion failed");

// next-cycle implication
`define NTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("neighbor table assertion failed");

`endif

// File: sv/nta_pkg.sv
// ----------------------------------------------------------------------------
// Neighbor table package
// Shared types, operation and status codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package nta_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int HISTORY_DEF = 16;

	typedef logic [1:0] op_t;
	typedef logic [2:0] status_t;

	localparam op_t OP_UPDATE = 2'd0;
	localparam op_t OP_FIND   = 2'd1;
	localparam op_t OP_PRUNE  = 2'd2;

	localparam status_t ST_SELF     = 3'd0;
	localparam status_t ST_UPDATED  = 3'd1;
	localparam status_t ST_INSERTED = 3'd2;
	localparam status_t ST_FULL     = 3'd3;
	localparam status_t ST_FOUND    = 3'd4;
	localparam status_t ST_MISSING  = 3'd5;
	localparam status_t ST_PRUNED   = 3'd6;

	localparam logic CFG_OWN_ID  = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	localparam logic [7:0]  OWN_ID_RST  = 8'd0;
	localparam logic [31:0] TIMEOUT_RST = 32'd1000;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] t;
	} hist_t;

endpackage

// File: sv/nta_ram.sv
// ----------------------------------------------------------------------------
// Neighbor table RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module nta_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/neighbor_table_with_aging.sv
// ----------------------------------------------------------------------------
// Neighbor table with aging
// Find/self/full/unused op: result via S_RESP and the output register, 1 per cycle unless out_ready stalls.
// Update: result via the S_UPD and S_RESP states; metadata RAM read-modify-write.
// Prune: result after the S_PRN walk over every slot; one metadata RAM read per slot.
// Reset clears state, active marks, count and output valid, reloads config defaults; RAM contents are kept.
// ----------------------------------------------------------------------------
`include "neighbor_table_with_aging_assert.svh"

module neighbor_table_with_aging #(
	parameter int SLOTS   = nta_pkg::SLOTS_DEF,
	parameter int HISTORY = nta_pkg::HISTORY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  nta_pkg::op_t     op,
	input  logic [7:0]       neighbor_id,
	input  logic [31:0]      pos_x,
	input  logic [31:0]      pos_y,
	input  logic [31:0]      pos_z,
	input  logic [31:0]      now_ms,
	output logic             out_valid,
	input  logic             out_ready,
	output nta_pkg::status_t status,
	output logic [3:0]       slot,
	output logic             slot_valid,
	output logic [4:0]       history_fill,
	output logic [4:0]       removed_count,
	output logic [4:0]       active_count
);

	import nta_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HW = (HISTORY > 1) ? $clog2(HISTORY) : 1;
	localparam int FW = $clog2(HISTORY + 1);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int HD = SLOTS * HISTORY;
	localparam int HA = (HD > 1) ? $clog2(HD) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_UPD  = 2'd1;
	localparam logic [1:0] S_PRN  = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	typedef struct packed {
		logic [31:0]   last;
		logic [HW-1:0] head;
		logic [FW-1:0] fill;
	} meta_t;

	logic [1:0]       state_q;
	logic [SLOTS-1:0] active_q;
	logic [7:0]       id_q [SLOTS];
	logic [CW-1:0]    total_q;
	logic [7:0]       own_id_q;
	logic [31:0]      timeout_q;

	logic [SW-1:0] slot_s1;
	logic          insert_s1;
	logic [7:0]    id_s1;
	hist_t         hist_s1;
	logic [SW-1:0] chk_q;

	status_t       res_status_q;
	logic [SW-1:0] res_slot_q;
	logic          res_valid_q;
	logic [FW-1:0] res_fill_q;
	logic [CW-1:0] res_removed_q;

	logic       out_valid_q;
	status_t    out_status_q;
	logic [3:0] out_slot_q;
	logic       out_slot_valid_q;
	logic [4:0] out_fill_q;
	logic [4:0] out_removed_q;
	logic [4:0] out_count_q;

	logic [SLOTS-1:0] match_v;
	logic             hit_any;
	logic [SW-1:0]    hit_slot;
	logic             free_any;
	logic [SW-1:0]    free_slot;
	logic             out_free;
	logic             take;
	logic             is_self;
	status_t          acc_status;
	logic [SW-1:0]    acc_slot;
	logic             acc_valid;
	logic [1:0]       acc_state;

	meta_t         meta_rd;
	meta_t         meta_wr;
	logic [SW-1:0] meta_raddr;
	logic          upd_we;
	logic [HW-1:0] cur_head;
	logic [FW-1:0] cur_fill;
	logic [HW-1:0] nxt_head;
	logic [FW-1:0] nxt_fill;
	logic [HA-1:0] hist_addr;
	logic [31:0]   age;
	logic          expire;
	logic          last_chk;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match_v[i] = active_q[i] && (id_q[i] == neighbor_id);
		end
	end

	always_comb begin
		hit_any   = 1'b0;
		hit_slot  = '0;
		free_any  = 1'b0;
		free_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match_v[i]) begin
				hit_any  = 1'b1;
				hit_slot = SW'(i);
			end
			if (!active_q[i]) begin
				free_any  = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) || ((state_q == S_RESP) && out_free);
	assign take     = in_valid && in_ready;
	assign is_self  = (neighbor_id == own_id_q);

	always_comb begin
		acc_status = ST_MISSING;
		acc_slot   = '0;
		acc_valid  = 1'b0;
		acc_state  = S_RESP;
		unique case (op)
			OP_UPDATE: begin
				if (is_self) begin
					acc_status = ST_SELF;
				end else if (hit_any) begin
					acc_status = ST_UPDATED;
					acc_state  = S_UPD;
				end else if (free_any) begin
					acc_status = ST_INSERTED;
					acc_state  = S_UPD;
				end else begin
					acc_status = ST_FULL;
				end
			end
			OP_FIND: begin
				if (hit_any) begin
					acc_status = ST_FOUND;
					acc_slot   = hit_slot;
					acc_valid  = 1'b1;
				end
			end
			OP_PRUNE: begin
				acc_status = ST_PRUNED;
				acc_state  = S_PRN;
			end
			default: begin
				acc_status = ST_MISSING;
			end
		endcase
	end

	always_comb begin
		if (state_q == S_PRN) begin
			meta_raddr = SW'(chk_q + 1'b1);
		end else if (op == OP_PRUNE) begin
			meta_raddr = '0;
		end else begin
			meta_raddr = hit_slot;
		end
	end

	assign upd_we   = (state_q == S_UPD);
	assign cur_head = insert_s1 ? '0 : meta_rd.head;
	assign cur_fill = insert_s1 ? '0 : meta_rd.fill;
	assign nxt_head = (cur_head == HW'(HISTORY - 1)) ? '0 : HW'(cur_head + 1'b1);
	assign nxt_fill = (cur_fill < FW'(HISTORY)) ? FW'(cur_fill + 1'b1) : cur_fill;
	assign hist_addr = HA'(HA'(slot_s1) * HA'(HISTORY)) + HA'(cur_head);

	assign meta_wr.last = hist_s1.t;
	assign meta_wr.head = nxt_head;
	assign meta_wr.fill = nxt_fill;

	assign age      = hist_s1.t - meta_rd.last;
	assign expire   = active_q[chk_q] && (age > timeout_q);
	assign last_chk = (chk_q == SW'(SLOTS - 1));

	nta_ram #(
		.WIDTH ($bits(meta_t)),
		.DEPTH (SLOTS)
	) u_meta_ram (
		.clk   (clk),
		.we    (upd_we),
		.waddr (slot_s1),
		.wdata (meta_wr),
		.raddr (meta_raddr),
		.rdata (meta_rd)
	);

	nta_ram #(
		.WIDTH ($bits(hist_t)),
		.DEPTH (HD)
	) u_hist_ram (
		.clk   (clk),
		.we    (upd_we),
		.waddr (hist_addr),
		.wdata (hist_s1),
		.raddr (hist_addr),
		.rdata ()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			own_id_q    <= OWN_ID_RST;
			timeout_q   <= TIMEOUT_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_OWN_ID:  own_id_q  <= cfg_wdata[7:0];
					CFG_TIMEOUT: timeout_q <= cfg_wdata;
					default:     ;
				endcase
			end
			if ((state_q == S_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q) inside
				S_IDLE, S_RESP: begin
					if (take) begin
						state_q <= acc_state;
					end else if (state_q == S_RESP && out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_UPD: begin
					if (insert_s1) begin
						active_q[slot_s1] <= 1'b1;
						total_q           <= total_q + 1'b1;
					end
					state_q <= S_RESP;
				end
				S_PRN: begin
					if (expire) begin
						active_q[chk_q] <= 1'b0;
						total_q         <= total_q - 1'b1;
					end
					if (last_chk) begin
						state_q <= S_RESP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			slot_s1       <= hit_any ? hit_slot : free_slot;
			insert_s1     <= !hit_any;
			id_s1         <= neighbor_id;
			hist_s1.x     <= pos_x;
			hist_s1.y     <= pos_y;
			hist_s1.z     <= pos_z;
			hist_s1.t     <= now_ms;
			chk_q         <= '0;
			res_status_q  <= acc_status;
			res_slot_q    <= acc_slot;
			res_valid_q   <= acc_valid;
			res_fill_q    <= '0;
			res_removed_q <= '0;
		end
		if (state_q == S_UPD) begin
			id_q[slot_s1] <= id_s1;
			res_status_q  <= insert_s1 ? ST_INSERTED : ST_UPDATED;
			res_slot_q    <= slot_s1;
			res_valid_q   <= 1'b1;
			res_fill_q    <= nxt_fill;
		end
		if (state_q == S_PRN) begin
			chk_q         <= SW'(chk_q + 1'b1);
			res_removed_q <= res_removed_q + CW'(expire);
		end
		if ((state_q == S_RESP) && out_free) begin
			out_status_q     <= res_status_q;
			out_slot_q       <= 4'(res_slot_q);
			out_slot_valid_q <= res_valid_q;
			out_fill_q       <= 5'(res_fill_q);
			out_removed_q    <= 5'(res_removed_q);
			out_count_q      <= 5'(total_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign slot          = out_slot_q;
	assign slot_valid    = out_slot_valid_q;
	assign history_fill  = out_fill_q;
	assign removed_count = out_removed_q;
	assign active_count  = out_count_q;

	`NTA_ASSERT_IMP(a_total_matches, clk, arst_n, 1'b1, total_q == CW'($countones(active_q)))
	`NTA_ASSERT_IMP(a_prune_busy, clk, arst_n, state_q == S_PRN, !in_ready)
	`NTA_ASSERT_NXT(a_upd_to_resp, clk, arst_n, state_q == S_UPD, state_q == S_RESP)
	`NTA_ASSERT_NXT(a_resp_loads, clk, arst_n, (state_q == S_RESP) && out_free, out_valid_q)

endmodule
